@@ src/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// Single button clock setter package
// Shared types and constants for the clock setter block.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

  // Operating mode of the setter.
  typedef enum logic [1:0] {
    MODE_UNSET   = 2'd0,
    MODE_HOURS   = 2'd1,
    MODE_MINUTES = 2'd2,
    MODE_RUNNING = 2'd3
  } mode_e;

  // Request type codes.
  localparam logic REQ_BUTTON = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [15:0] ThresholdReset = 16'd3000;
  localparam logic [18:0] MaxSeconds     = 19'd359999;

  // Reciprocal constants for exact division by 60 and by 10.
  localparam logic [19:0] Div60SecK = 20'd559241;  // 2^25 / 60, rounded up
  localparam logic [13:0] Div60MinK = 14'd8739;    // 2^19 / 60, rounded up
  localparam logic [7:0]  Div10K    = 8'd205;      // 2^11 / 10, rounded up

  localparam logic [12:0] SecPerHourMin = 13'd60;   // minutes per hour
  localparam logic [18:0] SecPerHour    = 19'd3600;
  localparam logic [18:0] SecPerMinute  = 19'd60;

  // One beat after the seconds conversion pipeline.
  typedef struct packed {
    logic        req_type;
    logic [15:0] held_count;
    logic [3:0]  hour_tens;
    logic [3:0]  hour_units;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_units;
  } item_t;

endpackage

`default_nettype wire

@@ src/scs_conv.sv @@
// ----------------------------------------------------------------------------
// Seconds to HH:MM conversion pipeline
// Four register stages that turn a seconds sample into four display digits,
// carrying the button fields along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_conv (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         req_type_i,
  input  wire logic [15:0]  held_count_i,
  input  wire logic [18:0]  time_seconds_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output scs_pkg::item_t    out_item_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic        req1_q, req2_q, req3_q;
  logic [15:0] held1_q, held2_q, held3_q;
  logic [18:0] secs1_q;
  logic [12:0] tmin2_q;
  logic [6:0]  hours3_q;
  logic [5:0]  mins3_q;
  scs_pkg::item_t item4_q;

  logic [18:0] sat_secs;
  logic [38:0] prod_sec;
  logic [26:0] prod_min;
  logic [6:0]  hours_c;
  logic [12:0] hours_min;
  logic [12:0] mins_full;
  logic [14:0] prod_ht;
  logic [13:0] prod_mt;
  logic [3:0]  ht_c;
  logic [2:0]  mt_c;
  logic [6:0]  hu_full;
  logic [5:0]  mu_full;

  // Each stage moves on when it is empty or the next one makes room.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 2 logic: saturate and take total minutes.
  always_comb begin
    sat_secs = (secs1_q > scs_pkg::MaxSeconds) ? scs_pkg::MaxSeconds : secs1_q;
    prod_sec = 39'(sat_secs) * 39'(scs_pkg::Div60SecK);
  end

  // Stage 3 logic: split total minutes into hours and minutes.
  always_comb begin
    prod_min  = 27'(tmin2_q) * 27'(scs_pkg::Div60MinK);
    hours_c   = prod_min[25:19];
    hours_min = 13'(hours_c) * scs_pkg::SecPerHourMin;
    mins_full = tmin2_q - hours_min;
  end

  // Stage 4 logic: split hours and minutes into decimal digits.
  always_comb begin
    prod_ht = 15'(hours3_q) * 15'(scs_pkg::Div10K);
    prod_mt = 14'(mins3_q) * 14'(scs_pkg::Div10K);
    ht_c    = prod_ht[14:11];
    mt_c    = prod_mt[13:11];
    hu_full = hours3_q - 7'(ht_c) * 7'd10;
    mu_full = mins3_q - 6'(mt_c) * 6'd10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      req1_q  <= req_type_i;
      held1_q <= held_count_i;
      secs1_q <= time_seconds_i;
    end
    if (v1_q && rdy2) begin
      req2_q  <= req1_q;
      held2_q <= held1_q;
      tmin2_q <= prod_sec[37:25];
    end
    if (v2_q && rdy3) begin
      req3_q   <= req2_q;
      held3_q  <= held2_q;
      hours3_q <= hours_c;
      mins3_q  <= mins_full[5:0];
    end
    if (v3_q && rdy4) begin
      item4_q.req_type     <= req3_q;
      item4_q.held_count   <= held3_q;
      item4_q.hour_tens    <= ht_c;
      item4_q.hour_units   <= hu_full[3:0];
      item4_q.minute_tens  <= mt_c;
      item4_q.minute_units <= mu_full[3:0];
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = item4_q;

endmodule

`default_nettype wire

@@ src/single_button_clock_setter_top.sv @@
// ----------------------------------------------------------------------------
// Single button clock setter
// Mode and HH:MM digit keeper for a clock that is set with one button.
// ----------------------------------------------------------------------------
// Usage: each input beat on the in channel (in_valid_i / in_ready_o) is either
// a button release (req_type_i = 0, held_count_i valid) or a seconds sample
// from the time counter (req_type_i = 1, time_seconds_i valid). Every input
// beat produces exactly one output beat on the out channel (out_valid_o /
// out_ready_i) with the digits and mode after the update, plus load_valid_o
// and load_seconds_o on the press that enters running mode.
// Pipeline: a beat passes the registers of the seconds-to-digits pipeline (the
// input register, a reciprocal multiply for total minutes, one for hours and
// minutes, one for the decimal digits), then the output register, which
// updates mode and digits.
// Throughput: one beat per cycle, sustained, since each stage hands on a beat
// every cycle as long as the receiver keeps out_ready_i high.
// Reset: mode unset, digits 00:00, long press threshold 3000, pipeline empty.
// Stall: with out_ready_i low the output holds, the pipeline fills its empty
// stages and in_ready_o drops once five beats wait. cfg_we_i / cfg_wdata_i
// write the threshold; the user writes only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module single_button_clock_setter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] held_count_i,
  input  wire logic [18:0] time_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       hour_tens_o,
  output logic [3:0]       hour_units_o,
  output logic [2:0]       minute_tens_o,
  output logic [3:0]       minute_units_o,
  output logic [1:0]       mode_o,
  output logic             load_valid_o,
  output logic [18:0]      load_seconds_o
);

  scs_pkg::item_t item;
  logic           conv_valid;
  logic           conv_ready;
  logic           fire;

  logic [15:0]    thr_q;
  scs_pkg::mode_e mode_q, mode_d;
  logic [3:0]     ht_q, ht_d;
  logic [3:0]     hu_q, hu_d;
  logic [2:0]     mt_q, mt_d;
  logic [3:0]     mu_q, mu_d;
  logic           out_valid_q;
  logic           load_valid_q, load_valid_d;
  logic [18:0]    load_seconds_q, load_seconds_d;

  logic           is_button;
  logic           long_press;
  logic           short_press;
  logic [6:0]     hours_val;
  logic [5:0]     mins_val;
  logic [18:0]    set_seconds;

  scs_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .held_count_i   (held_count_i),
    .time_seconds_i (time_seconds_i),
    .out_valid_o    (conv_valid),
    .out_ready_i    (conv_ready),
    .out_item_o     (item)
  );

  // The mode and digit registers are the output register: they only change
  // when a beat moves in, which needs the output slot to be free or leaving.
  assign conv_ready = !out_valid_q || out_ready_i;
  assign fire       = conv_valid && conv_ready;

  assign is_button   = (item.req_type == scs_pkg::REQ_BUTTON);
  assign long_press  = is_button && (item.held_count > thr_q);
  assign short_press = is_button && (item.held_count < thr_q);

  // Seconds value to load, taken from the digits being set.
  always_comb begin
    hours_val   = 7'(ht_q) * 7'd10 + 7'(hu_q);
    mins_val    = 6'(mt_q) * 6'd10 + 6'(mu_q);
    set_seconds = 19'(hours_val) * scs_pkg::SecPerHour
                + 19'(mins_val) * scs_pkg::SecPerMinute;
  end

  // Next mode: a long press walks unset, hours, minutes, running, and from
  // running back to setting hours.
  always_comb begin
    mode_d = mode_q;
    if (fire && long_press) begin
      case (mode_q)
        scs_pkg::MODE_UNSET:   mode_d = scs_pkg::MODE_HOURS;
        scs_pkg::MODE_HOURS:   mode_d = scs_pkg::MODE_MINUTES;
        scs_pkg::MODE_MINUTES: mode_d = scs_pkg::MODE_RUNNING;
        scs_pkg::MODE_RUNNING: mode_d = scs_pkg::MODE_HOURS;
        default:               mode_d = mode_q;
      endcase
    end
  end

  // Digits and load request. A short press steps the field being set, a
  // sample in running mode replaces all four digits.
  always_comb begin
    ht_d           = ht_q;
    hu_d           = hu_q;
    mt_d           = mt_q;
    mu_d           = mu_q;
    load_valid_d   = 1'b0;
    load_seconds_d = '0;
    if (short_press) begin
      case (mode_q)
        scs_pkg::MODE_HOURS: begin
          if (ht_q == 4'd2 && hu_q < 4'd3) begin
            hu_d = hu_q + 4'd1;
          end else if (ht_q == 4'd2) begin
            ht_d = '0;
            hu_d = '0;
          end else if (hu_q < 4'd9) begin
            hu_d = hu_q + 4'd1;
          end else begin
            hu_d = '0;
            ht_d = (ht_q < 4'd2) ? ht_q + 4'd1 : '0;
          end
        end
        scs_pkg::MODE_MINUTES: begin
          if (mt_q == 3'd5 && mu_q < 4'd9) begin
            mu_d = mu_q + 4'd1;
          end else if (mt_q == 3'd5) begin
            mt_d = '0;
            mu_d = '0;
          end else if (mu_q < 4'd9) begin
            mu_d = mu_q + 4'd1;
          end else begin
            mu_d = '0;
            mt_d = (mt_q < 3'd5) ? mt_q + 3'd1 : '0;
          end
        end
        default: begin
          ht_d = ht_q;
        end
      endcase
    end else if (long_press) begin
      if (mode_q == scs_pkg::MODE_MINUTES) begin
        load_valid_d   = 1'b1;
        load_seconds_d = set_seconds;
      end
    end else if (!is_button && mode_q == scs_pkg::MODE_RUNNING) begin
      ht_d = item.hour_tens;
      hu_d = item.hour_units;
      mt_d = item.minute_tens;
      mu_d = item.minute_units;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= scs_pkg::ThresholdReset;
      mode_q      <= scs_pkg::MODE_UNSET;
      ht_q        <= '0;
      hu_q        <= '0;
      mt_q        <= '0;
      mu_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (conv_ready) out_valid_q <= conv_valid;
      if (fire) begin
        mode_q <= mode_d;
        ht_q   <= ht_d;
        hu_q   <= hu_d;
        mt_q   <= mt_d;
        mu_q   <= mu_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      load_valid_q   <= load_valid_d;
      load_seconds_q <= load_seconds_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hour_tens_o    = ht_q;
  assign hour_units_o   = hu_q;
  assign minute_tens_o  = mt_q;
  assign minute_units_o = mu_q;
  assign mode_o         = 2'(mode_q);
  assign load_valid_o   = load_valid_q;
  assign load_seconds_o = load_seconds_q;

  // A load request only comes with the switch into running mode.
  a_load_in_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_valid_o) |-> (mode_o == 2'(scs_pkg::MODE_RUNNING)))
    else $error("load request outside running mode");

  // Without a load request the load value reads as zero.
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !load_valid_o) |-> (load_seconds_o == '0))
    else $error("load value set without load request");

  // Minute digits stay within the clock range and hour digits at most nine.
  a_minute_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (minute_tens_o <= 3'd5 && minute_units_o <= 4'd9
                     && hour_units_o <= 4'd9 && hour_tens_o <= 4'd9))
    else $error("display digit out of range");

  // Mode changes only when a beat enters the output stage.
  a_mode_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != $past(mode_q)) |-> $past(fire))
    else $error("mode changed without a beat");

endmodule

`default_nettype wire
